// ===== sv/jild_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jild_pkg: shared types and constants of the bytecode length decoder
// Opcode encoding table, class and status codes, request and result records.
// ----------------------------------------------------------------------------
package jild_pkg;

  localparam int unsigned LEN_W = 35;

  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_NOFALL = 2'd1,
    KIND_FAST   = 2'd2,
    KIND_VAR    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_INSN = 2'd1,
    STATUS_BAD_ARG  = 2'd2
  } status_t;

  // Encoding: zero undefined; 30h..32h special; else 2:0 length, 5:4 class.
  localparam logic [7:0] ENC_UNDEF        = 8'h00;
  localparam logic [7:0] ENC_TABLESWITCH  = 8'h30;
  localparam logic [7:0] ENC_LOOKUPSWITCH = 8'h31;
  localparam logic [7:0] ENC_WIDE         = 8'h32;

  localparam logic [7:0] OP_ILOAD  = 8'd21;
  localparam logic [7:0] OP_ALOAD  = 8'd25;
  localparam logic [7:0] OP_ISTORE = 8'd54;
  localparam logic [7:0] OP_ASTORE = 8'd58;
  localparam logic [7:0] OP_IINC   = 8'd132;
  localparam logic [7:0] OP_JSR_W_FAST0 = 8'd168;
  localparam logic [7:0] OP_FAST1  = 8'd169;
  localparam logic [7:0] OP_FAST2  = 8'd186;
  localparam logic [7:0] OP_FAST_BASE = 8'd201;

  localparam logic [LEN_W-1:0] LEN_WIDE      = 35'd4;
  localparam logic [LEN_W-1:0] LEN_WIDE_IINC = 35'd6;
  localparam logic [LEN_W-1:0] TS_HEADER     = 35'd12;
  localparam logic [LEN_W-1:0] LS_HEADER     = 35'd8;

  localparam logic [7:0] OP_TAB [0:255] = '{
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h02, 8'h03, 8'h02, 8'h03, 8'h03, 8'h02, 8'h02, 8'h02,
    8'h02, 8'h02, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h02, 8'h02,
    8'h02, 8'h02, 8'h02, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h03, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03,
    8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h13,
    8'h00, 8'h00, 8'h30, 8'h31, 8'h11, 8'h11, 8'h11, 8'h11,
    8'h11, 8'h11, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03,
    8'h03, 8'h05, 8'h00, 8'h03, 8'h02, 8'h03, 8'h01, 8'h11,
    8'h03, 8'h03, 8'h01, 8'h01, 8'h32, 8'h04, 8'h03, 8'h03,
    8'h15, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h21, 8'h21
  };

  typedef struct packed {
    logic [7:0]         opcode;
    logic [7:0]         following_byte;
    logic [1:0]         pc_phase;
    logic signed [31:0] first_word;
    logic signed [31:0] second_word;
  } req_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    kind_t            kind;
    logic             fast_handlers;
    status_t          status;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/jild_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jild_if: request and result channels of the bytecode length decoder
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface jild_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         opcode;
  logic [7:0]         following_byte;
  logic [1:0]         pc_phase;
  logic signed [31:0] first_word;
  logic signed [31:0] second_word;

  modport source (output valid, output opcode, output following_byte, output pc_phase,
                  output first_word, output second_word, input ready);
  modport sink (input valid, input opcode, input following_byte, input pc_phase,
                input first_word, input second_word, output ready);
endinterface

interface jild_out_if;
  logic                         valid;
  logic                         ready;
  logic [jild_pkg::LEN_W-1:0]   length;
  logic [1:0]                   kind;
  logic                         fast_handlers;
  logic [1:0]                   status;

  modport source (output valid, output length, output kind, output fast_handlers,
                  output status, input ready);
  modport sink (input valid, input length, input kind, input fast_handlers,
                input status, output ready);
endinterface
`default_nettype wire

// ===== sv/jild_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jild_decode: single-pass length and class decode
// Table lookup for fixed opcodes, header arithmetic for switches, wide check.
// ----------------------------------------------------------------------------
module jild_decode (
  input  jild_pkg::req_t    req,
  output jild_pkg::result_t res
);

  logic [7:0]                 enc;
  logic [jild_pkg::LEN_W-1:0] fill;
  logic signed [32:0]         bound_diff;
  logic [32:0]                case_cnt;
  logic [jild_pkg::LEN_W-1:0] ts_len;
  logic [jild_pkg::LEN_W-1:0] ls_len;
  logic                       wide_plain;
  logic                       fast_op;

  assign enc        = jild_pkg::OP_TAB[req.opcode];
  assign fill       = jild_pkg::LEN_W'(3'd4 - {1'b0, req.pc_phase});
  assign bound_diff = {req.second_word[31], req.second_word}
                    - {req.first_word[31], req.first_word};
  assign case_cnt   = {1'b0, bound_diff[31:0]} + 33'd1;
  assign ts_len     = {case_cnt, 2'b00} + fill + jild_pkg::TS_HEADER;
  assign ls_len     = {1'b0, req.first_word[30:0], 3'b000} + fill + jild_pkg::LS_HEADER;
  assign wide_plain = (req.following_byte >= jild_pkg::OP_ILOAD &&
                       req.following_byte <= jild_pkg::OP_ALOAD) ||
                      (req.following_byte >= jild_pkg::OP_ISTORE &&
                       req.following_byte <= jild_pkg::OP_ASTORE);
  assign fast_op    = req.opcode == jild_pkg::OP_JSR_W_FAST0 ||
                      req.opcode == jild_pkg::OP_FAST1 ||
                      req.opcode == jild_pkg::OP_FAST2 ||
                      req.opcode >= jild_pkg::OP_FAST_BASE;

  always_comb begin
    res.length        = '0;
    res.kind          = jild_pkg::KIND_NORMAL;
    res.fast_handlers = fast_op;
    res.status        = jild_pkg::STATUS_OK;
    unique case (enc)
      jild_pkg::ENC_UNDEF: begin
        res.status = jild_pkg::STATUS_BAD_ARG;
      end
      jild_pkg::ENC_TABLESWITCH: begin
        res.kind = jild_pkg::KIND_VAR;
        if (bound_diff[32]) begin
          res.status = jild_pkg::STATUS_BAD_INSN;
        end else begin
          res.length = ts_len;
        end
      end
      jild_pkg::ENC_LOOKUPSWITCH: begin
        res.kind = jild_pkg::KIND_VAR;
        if (req.first_word[31]) begin
          res.status = jild_pkg::STATUS_BAD_INSN;
        end else begin
          res.length = ls_len;
        end
      end
      jild_pkg::ENC_WIDE: begin
        res.kind = jild_pkg::KIND_VAR;
        if (wide_plain) begin
          res.length = jild_pkg::LEN_WIDE;
        end else if (req.following_byte == jild_pkg::OP_IINC) begin
          res.length = jild_pkg::LEN_WIDE_IINC;
        end else begin
          res.status = jild_pkg::STATUS_BAD_ARG;
        end
      end
      default: begin
        res.length = jild_pkg::LEN_W'(enc[2:0]);
        res.kind   = jild_pkg::kind_t'(enc[5:4]);
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/jvm_instruction_length_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jvm_instruction_length_decoder_unit: bytecode instruction length decoder
// Registers each request, decodes length, class and status, registers result.
//
//   Channel  Dir  Handshake          Payload
//   in_req   in   valid / ready      opcode, following_byte, pc_phase, words
//   out_res  out  valid / ready      length, kind, fast_handlers, status
//
// One request per cycle while the result is not stalled.
// The path is input register, decode logic, result register.
// Synchronous active-low reset empties both registers.
// A stalled result holds; input stays ready unless both registers are full and the result is stalled.
// ----------------------------------------------------------------------------
module jvm_instruction_length_decoder_unit (
  input  wire           clk,
  input  wire           rst_n,
  jild_in_if.sink       in_req,
  jild_out_if.source    out_res
);

  logic              req_valid_r;
  jild_pkg::req_t    req_r;
  logic              res_valid_r;
  jild_pkg::result_t res_r;
  jild_pkg::result_t res_nxt;
  logic              res_adv;
  logic              req_adv;

  assign res_adv      = !res_valid_r || out_res.ready;
  assign req_adv      = req_valid_r && res_adv;
  assign in_req.ready = !req_valid_r || res_adv;

  jild_decode u_decode (
    .req (req_r),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      req_valid_r <= in_req.valid;
    end
    if (in_req.ready && in_req.valid) begin
      req_r.opcode         <= in_req.opcode;
      req_r.following_byte <= in_req.following_byte;
      req_r.pc_phase       <= in_req.pc_phase;
      req_r.first_word     <= in_req.first_word;
      req_r.second_word    <= in_req.second_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_adv) begin
      res_valid_r <= req_valid_r;
    end
    if (req_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid         = res_valid_r;
  assign out_res.length        = res_r.length;
  assign out_res.kind          = res_r.kind;
  assign out_res.fast_handlers = res_r.fast_handlers;
  assign out_res.status        = res_r.status;

endmodule
`default_nettype wire

// ===== sv/jild_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jild_check: port-level checks of the bytecode length decoder
// Channel behavior and result consistency seen at the top level ports.
// ----------------------------------------------------------------------------
module jild_check (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_ready,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire [jild_pkg::LEN_W-1:0]   out_length,
  input wire [1:0]                   out_kind,
  input wire                         out_fast,
  input wire [1:0]                   out_status
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_length) && $stable(out_status))
    else $error("stalled result changed");

  // drop input ready only behind a stalled result
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != jild_pkg::STATUS_OK |-> out_length == '0)
    else $error("error result with nonzero length");

  a_bad_insn_var: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == jild_pkg::STATUS_BAD_INSN |-> out_kind == jild_pkg::KIND_VAR)
    else $error("bad switch header on non-switch class");

  a_fast_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fast && out_status == jild_pkg::STATUS_OK
      |-> out_kind == jild_pkg::KIND_FAST && out_length == 35'd1)
    else $error("defined fast opcode decoded wrongly");

endmodule

bind jvm_instruction_length_decoder_unit jild_check u_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_req.ready),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .out_length (out_res.length),
  .out_kind   (out_res.kind),
  .out_fast   (out_res.fast_handlers),
  .out_status (out_res.status)
);
`default_nettype wire
